FILE: hdl/timed_mask_event_sequencer_assert.svh
// assertion macros shared by the sequencer modules
// no dependencies
`ifndef TIMED_MASK_EVENT_SEQUENCER_ASSERT_SVH
`define TIMED_MASK_EVENT_SEQUENCER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TMES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define TMES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tmes_pkg.sv
// shared types and codes for the timed mask event sequencer
// no dependencies
package tmes_pkg;

	localparam int unsigned QueueSlotsDef = 8;
	localparam int unsigned MaxEventsDef = 32;

	localparam logic [2:0] OP_HEADER = 3'd0;
	localparam logic [2:0] OP_EVENT = 3'd1;
	localparam logic [2:0] OP_TICK = 3'd2;
	localparam logic [2:0] OP_RETIRE = 3'd3;
	localparam logic [2:0] OP_HALT = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_TYPE = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_EV_RD,
		S_EV_CHK,
		S_EV_NEXT,
		S_SLOT_NEXT,
		S_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec_simple;
		logic slot_first;
		logic slot_rd;
		logic slot_next;
		logic ev_first;
		logic ev_rd;
		logic ev_next;
		logic ev_hit;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic playing;
		logic slot_match;
		logic slots_done;
		logic ev_done;
		logic ev_bracket;
	} dp_stat_t;

endpackage

FILE: hdl/tmes_ctrl.sv
// sequencing controller for the timed mask event sequencer
// depends on tmes_pkg and the assertion header
`include "timed_mask_event_sequencer_assert.svh"
module tmes_ctrl
	import tmes_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     idle
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.is_tick && stat.playing) state_d = S_SLOT_RD;
				else state_d = S_DONE;
			end
			S_SLOT_RD: state_d = S_SLOT_CHK;
			S_SLOT_CHK: begin
				if (stat.slot_match) state_d = S_EV_RD;
				else state_d = S_SLOT_NEXT;
			end
			S_SLOT_NEXT: begin
				if (stat.slots_done) state_d = S_DONE;
				else state_d = S_SLOT_RD;
			end
			S_EV_RD: begin
				if (stat.ev_done) state_d = S_DONE;
				else state_d = S_EV_CHK;
			end
			S_EV_CHK: begin
				if (stat.ev_bracket) state_d = S_DONE;
				else state_d = S_EV_NEXT;
			end
			S_EV_NEXT: state_d = S_EV_RD;
			S_DONE: begin
				if (!out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				cmd.capture = in_fire;
			end
			S_DECODE: begin
				cmd.exec_simple = !stat.is_tick;
				cmd.slot_first = 1'b1;
			end
			S_SLOT_RD: cmd.slot_rd = 1'b1;
			S_SLOT_CHK: cmd.ev_first = 1'b1;
			S_SLOT_NEXT: cmd.slot_next = 1'b1;
			S_EV_RD: cmd.ev_rd = 1'b1;
			S_EV_CHK: cmd.ev_hit = stat.ev_bracket;
			S_EV_NEXT: cmd.ev_next = 1'b1;
			S_DONE: cmd.finish = !out_busy;
			default: cmd = '0;
		endcase
	end

	`TMES_ASSERT_IMP(a_capture_idle, clk, arst_n, cmd.capture, state_q == S_IDLE, "capture outside idle")
	`TMES_ASSERT_NXT(a_capture_decode, clk, arst_n, cmd.capture, state_q == S_DECODE, "capture not followed by decode")
	`TMES_ASSERT_IMP(a_finish_done, clk, arst_n, cmd.finish, state_q == S_DONE, "finish outside done")

endmodule

FILE: hdl/tmes_datapath.sv
// segment ring, event store and result register of the sequencer
// depends on tmes_pkg and the assertion header
`include "timed_mask_event_sequencer_assert.svh"
module tmes_datapath
	import tmes_pkg::*;
#(
	parameter int unsigned QUEUE_SLOTS = QueueSlotsDef,
	parameter int unsigned MAX_EVENTS = MaxEventsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [7:0]  track_key,
	input  logic [2:0]  operation,
	input  logic [31:0] time_now,
	input  logic [31:0] seg_start,
	input  logic [31:0] seg_end,
	input  logic [5:0]  num_events,
	input  logic [7:0]  track_type,
	input  logic [31:0] event_stamp,
	input  logic [7:0]  event_mask,
	output logic        out_valid_q,
	input  logic        out_taken,
	output logic [1:0]  res_status_q,
	output logic        res_mask_valid_q,
	output logic [7:0]  res_mask_q,
	output logic        res_retired_q,
	output logic        res_loaded_q
);

	localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int EW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CW = $clog2(MAX_EVENTS + 1);
	localparam int DEPTH = QUEUE_SLOTS * MAX_EVENTS;
	localparam int AW = $clog2(DEPTH);
	localparam logic [SW-1:0] LastSlot = SW'(QUEUE_SLOTS - 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_EVENTS);

	// captured item
	logic [2:0]  op_q;
	logic [31:0] now_q, start_in_q, end_in_q, stamp_in_q;
	logic [5:0]  n_q;
	logic [7:0]  type_q, mask_in_q;

	// ring state
	logic [QUEUE_SLOTS-1:0] live_q;
	logic [31:0] slot_start_q [QUEUE_SLOTS];
	logic [31:0] slot_end_q [QUEUE_SLOTS];
	logic [CW-1:0] slot_cnt_q [QUEUE_SLOTS];
	logic [SW-1:0] head_q, tail_q;
	logic [5:0]  load_count_q, load_total_q;
	logic        loading_q, playing_q;
	logic [7:0]  last_mask_q;

	// event memory
	logic [31:0] stamp_mem [DEPTH];
	logic [7:0]  mask_mem [DEPTH];
	logic [31:0] rd_stamp_a_q, rd_stamp_b_q;
	logic [7:0]  rd_mask_q;

	// tick walk
	logic [SW-1:0] walk_slot_q;
	logic [SW:0]   walk_cnt_q;
	logic [31:0]   w_start_q, w_end_q, rel_q;
	logic [CW-1:0] w_cnt_q;
	logic          w_live_q;
	logic [EW:0]   ev_q;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		slot_inc = (s == LastSlot) ? '0 : s + 1'b1;
	endfunction

	logic [SW-1:0] head_nx;
	logic          load_cnt_room;
	logic [EW-1:0] load_ev;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [5:0]    load_count_inc;
	logic [CW-1:0] n_clip;

	assign head_nx = slot_inc(head_q);
	assign load_cnt_room = {2'b0, load_count_q} < {2'b0, 6'(MAX_EVENTS > 63 ? 63 : MAX_EVENTS)}
		|| (MAX_EVENTS > 63);
	assign load_ev = load_count_q[EW-1:0];
	assign wr_addr = AW'(head_q) * AW'(MAX_EVENTS) + AW'(load_ev);
	assign rd_addr = AW'(walk_slot_q) * AW'(MAX_EVENTS) + AW'(ev_q[EW-1:0]);
	assign load_count_inc = load_count_q + 6'd1;
	assign n_clip = ({2'b0, n_q} > {2'b0, 6'(0)} + MaxCnt) ? MaxCnt : CW'(n_q);

	assign stat.is_tick = (op_q == OP_TICK);
	assign stat.playing = playing_q;
	assign stat.slot_match = w_live_q && (w_start_q <= now_q) && (now_q < w_end_q);
	assign stat.slots_done = (walk_cnt_q == (SW+1)'(QUEUE_SLOTS - 1));
	assign stat.ev_done = ((CW+1)'(ev_q) + 1 >= (CW+1)'(w_cnt_q));
	assign stat.ev_bracket = (rd_stamp_a_q < rel_q) && (rel_q < rd_stamp_b_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			now_q <= time_now;
			start_in_q <= seg_start;
			end_in_q <= seg_end;
			n_q <= num_events;
			type_q <= track_type;
			stamp_in_q <= event_stamp;
			mask_in_q <= event_mask;
		end
		if (cmd.exec_simple && op_q == OP_HEADER && !live_q[head_nx] && type_q == track_key) begin
			slot_start_q[head_q] <= start_in_q;
			slot_end_q[head_q] <= end_in_q;
			slot_cnt_q[head_q] <= n_clip;
		end
		if (cmd.exec_simple && op_q == OP_EVENT && loading_q && load_cnt_room) begin
			stamp_mem[wr_addr] <= stamp_in_q;
			mask_mem[wr_addr] <= mask_in_q;
		end
		if (cmd.slot_rd) begin
			w_live_q <= live_q[walk_slot_q];
			w_start_q <= slot_start_q[walk_slot_q];
			w_end_q <= slot_end_q[walk_slot_q];
			w_cnt_q <= slot_cnt_q[walk_slot_q];
		end
		if (cmd.ev_first) rel_q <= now_q - w_start_q;
		// two consecutive stamp entries, read in the same cycle through two read ports
		if (cmd.ev_rd) begin
			rd_stamp_a_q <= stamp_mem[rd_addr];
			rd_mask_q <= mask_mem[rd_addr];
			rd_stamp_b_q <= stamp_mem[rd_addr + AW'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			load_count_q <= '0;
			load_total_q <= '0;
			loading_q <= 1'b0;
			playing_q <= 1'b0;
			last_mask_q <= '0;
			walk_slot_q <= '0;
			walk_cnt_q <= '0;
			ev_q <= '0;
			out_valid_q <= 1'b0;
			res_status_q <= ST_OK;
			res_mask_valid_q <= 1'b0;
			res_mask_q <= '0;
			res_retired_q <= 1'b0;
			res_loaded_q <= 1'b0;
		end else begin
			if (out_taken) out_valid_q <= 1'b0;
			if (cmd.capture) begin
				res_status_q <= ST_OK;
				res_mask_valid_q <= 1'b0;
				res_mask_q <= '0;
				res_retired_q <= 1'b0;
				res_loaded_q <= 1'b0;
			end
			if (cmd.exec_simple) begin
				case (op_q)
					OP_HEADER: begin
						if (live_q[head_nx]) begin
							res_status_q <= ST_FULL;
						end else if (type_q != track_key) begin
							res_status_q <= ST_TYPE;
						end else if (n_q == 6'd0) begin
							live_q[head_q] <= 1'b1;
							head_q <= head_nx;
							loading_q <= 1'b0;
							load_count_q <= '0;
							load_total_q <= '0;
							playing_q <= 1'b1;
							res_loaded_q <= 1'b1;
						end else begin
							load_total_q <= n_q;
							load_count_q <= '0;
							loading_q <= 1'b1;
						end
					end
					OP_EVENT: begin
						if (!loading_q) begin
							res_status_q <= ST_DROP;
						end else begin
							if (!load_cnt_room) res_status_q <= ST_DROP;
							if (load_count_inc >= load_total_q) begin
								live_q[head_q] <= 1'b1;
								head_q <= head_nx;
								loading_q <= 1'b0;
								load_count_q <= '0;
								playing_q <= 1'b1;
								res_loaded_q <= 1'b1;
							end else begin
								load_count_q <= load_count_inc;
							end
						end
					end
					OP_RETIRE: begin
						if (live_q[tail_q] && slot_end_q[tail_q] < now_q) begin
							live_q[tail_q] <= 1'b0;
							tail_q <= slot_inc(tail_q);
							res_retired_q <= 1'b1;
						end
					end
					OP_HALT: begin
						live_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						load_count_q <= '0;
						load_total_q <= '0;
						loading_q <= 1'b0;
						playing_q <= 1'b0;
						last_mask_q <= '0;
					end
					default: res_status_q <= ST_DROP;
				endcase
			end
			if (cmd.slot_first) begin
				walk_slot_q <= tail_q;
				walk_cnt_q <= '0;
			end
			if (cmd.slot_next) begin
				walk_slot_q <= slot_inc(walk_slot_q);
				walk_cnt_q <= walk_cnt_q + 1'b1;
			end
			if (cmd.ev_first) ev_q <= '0;
			if (cmd.ev_next) ev_q <= ev_q + 1'b1;
			if (cmd.ev_hit && rd_mask_q != last_mask_q) begin
				last_mask_q <= rd_mask_q;
				res_mask_valid_q <= 1'b1;
				res_mask_q <= rd_mask_q;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
		end
	end

	`TMES_ASSERT_IMP(a_mask_changed, clk, arst_n, cmd.ev_hit && rd_mask_q != last_mask_q, rd_mask_q != 8'd0 || last_mask_q != 8'd0, "emitted mask equals last mask")
	`TMES_ASSERT_NXT(a_load_live, clk, arst_n, cmd.exec_simple && op_q == OP_HEADER && n_q == 6'd0 && !live_q[head_nx] && type_q == track_key, res_loaded_q && playing_q, "empty segment did not go live")
	`TMES_ASSERT_IMP(a_no_capture_busy, clk, arst_n, cmd.capture, !out_valid_q || out_taken, "item taken while result pending")

endmodule

FILE: hdl/timed_mask_event_sequencer.sv
// header, event, retire and halt items: captured in idle, executed in decode, result posted from done
// tick: while playing, walks the slots from the tail and then the events of the first matching slot
// one item in flight; a new item is taken only in idle, once the result register is free
// reset clears ring, mode, last mask and track key; stores hold unknown data until written
// depends on tmes_pkg, tmes_ctrl and tmes_datapath
module timed_mask_event_sequencer
	import tmes_pkg::*;
#(
	parameter int unsigned QUEUE_SLOTS = QueueSlotsDef,
	parameter int unsigned MAX_EVENTS = MaxEventsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] time_now,
	input  logic [31:0] seg_start,
	input  logic [31:0] seg_end,
	input  logic [5:0]  num_events,
	input  logic [7:0]  track_type,
	input  logic [31:0] event_stamp,
	input  logic [7:0]  event_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        mask_valid,
	output logic [7:0]  mask_out,
	output logic        retired,
	output logic        segment_loaded
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     idle;
	logic     in_fire;
	logic [7:0] track_key_q;

	assign cfg_ready = 1'b1;
	assign in_ready = idle && (!out_valid || out_ready);
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_key_q <= '0;
		end else if (cfg_valid) begin
			track_key_q <= cfg_data;
		end
	end

	tmes_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.out_busy(out_valid && !out_ready),
		.stat    (stat),
		.cmd     (cmd),
		.idle    (idle)
	);

	tmes_datapath #(
		.QUEUE_SLOTS(QUEUE_SLOTS),
		.MAX_EVENTS (MAX_EVENTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.track_key       (track_key_q),
		.operation       (operation),
		.time_now        (time_now),
		.seg_start       (seg_start),
		.seg_end         (seg_end),
		.num_events      (num_events),
		.track_type      (track_type),
		.event_stamp     (event_stamp),
		.event_mask      (event_mask),
		.out_valid_q     (out_valid),
		.out_taken       (out_valid && out_ready),
		.res_status_q    (status),
		.res_mask_valid_q(mask_valid),
		.res_mask_q      (mask_out),
		.res_retired_q   (retired),
		.res_loaded_q    (segment_loaded)
	);

endmodule
